// ===== rtl/rtrus_pkg.sv =====
package rtrus_pkg;

  localparam int unsigned RAW_W  = 56;
  localparam int unsigned DAYS_W = 17;
  localparam int unsigned SEC_W  = 34;

  localparam logic [16:0] DAY_SEC  = 17'd86400;
  localparam logic [11:0] HOUR_SEC = 12'd3600;
  localparam logic [5:0]  MIN_SEC  = 6'd60;

  localparam logic [8:0]  EPOCH_YEARS  = 9'd30;   // 1970 .. 1999
  localparam logic [7:0]  EPOCH_LEAPS  = 8'd7;    // leap years 1972 .. 1996
  localparam logic [8:0]  YEAR_DAYS    = 9'd365;
  localparam logic [7:0]  CENTURY_2100 = 8'd100;
  localparam logic [7:0]  CENTURY_2200 = 8'd200;

  localparam int unsigned ST_BINARY = 2;
  localparam int unsigned ST_24H    = 1;

  // snapshot, second in the low byte
  typedef struct packed {
    logic [7:0] status;
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
  } rtrus_raw_t;

  typedef struct packed {
    logic              valid;
    logic [DAYS_W-1:0] days;
    logic [7:0]        hour;
    logic [7:0]        minute;
    logic [7:0]        second;
  } rtrus_dec_t;

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    logic [7:0] tens;
    tens = {4'd0, v[7:4]};
    return 8'({4'd0, v[3:0]} + ((tens << 3) + (tens << 1)));
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/rtrus_decode.sv =====
module rtrus_decode
  import rtrus_pkg::*;
(
  input  rtrus_raw_t raw,
  output rtrus_dec_t dec
);

  logic       binary;
  logic       h24;
  logic [7:0] sec_d;
  logic [7:0] min_d;
  logic [7:0] hr_d;
  logic [7:0] hr_bcd;
  logic [7:0] day_d;
  logic [7:0] mon_d;
  logic [7:0] yr_d;
  logic [6:0] hr_low;
  logic [3:0] hr_q;
  logic [6:0] hr_mod;
  logic [7:0] hr_f;
  logic [7:0] leaps;
  logic       leap_yr;
  logic [8:0] years;
  logic [DAYS_W-1:0] base;

  assign binary = raw.status[ST_BINARY];
  assign h24    = raw.status[ST_24H];
  assign hr_bcd = bcd_to_bin({1'b0, raw.hour[6:0]});

  always_comb begin
    if (binary) begin
      sec_d = raw.second;
      min_d = raw.minute;
      hr_d  = raw.hour;
      day_d = raw.day;
      mon_d = raw.month;
      yr_d  = raw.year;
    end else begin
      sec_d = bcd_to_bin(raw.second);
      min_d = bcd_to_bin(raw.minute);
      hr_d  = {raw.hour[7], hr_bcd[6:0]};
      day_d = bcd_to_bin(raw.day);
      mon_d = bcd_to_bin(raw.month);
      yr_d  = bcd_to_bin(raw.year);
    end
  end

  // hour mod 12 by reciprocal, exact for 0..127
  assign hr_low = hr_d[6:0];
  assign hr_q   = 4'((14'(hr_low) * 14'd43) >> 9);
  assign hr_mod = 7'(hr_low - 7'(hr_q * 7'd12));

  always_comb begin
    if (h24) begin
      hr_f = hr_d;
    end else if (hr_d[7]) begin
      hr_f = 8'(hr_mod) + 8'd12;
    end else if (hr_low == 7'd12) begin
      hr_f = 8'd0;
    end else begin
      hr_f = {1'b0, hr_low};
    end
  end

  // leap years in 1970 .. 2000+yr-1
  assign leaps = 8'((9'(yr_d) + 9'd3) >> 2) - 8'(yr_d > CENTURY_2100)
               - 8'(yr_d > CENTURY_2200) + EPOCH_LEAPS;
  assign leap_yr = (yr_d[1:0] == 2'd0) && (yr_d != CENTURY_2100) && (yr_d != CENTURY_2200);

  assign years = 9'(yr_d) + EPOCH_YEARS;
  assign base  = DAYS_W'(years) * DAYS_W'(YEAR_DAYS);

  always_comb begin
    dec.valid  = (mon_d >= 8'd1) && (mon_d <= 8'd12) && (day_d >= 8'd1) && (day_d <= 8'd31);
    dec.days   = base + DAYS_W'(leaps) + DAYS_W'(month_start(mon_d[3:0])) + DAYS_W'(day_d)
               - DAYS_W'(1) + DAYS_W'(leap_yr && (mon_d > 8'd2));
    dec.hour   = hr_f;
    dec.minute = min_d;
    dec.second = sec_d;
  end

endmodule

// ===== rtl/rtrus_seconds.sv =====
module rtrus_seconds
  import rtrus_pkg::*;
(
  input  rtrus_dec_t       dec,
  output logic             time_valid,
  output logic [SEC_W-1:0] unix_seconds
);

  logic [SEC_W-1:0] total;

  assign total = SEC_W'(dec.days) * SEC_W'(DAY_SEC)
               + SEC_W'(dec.hour) * SEC_W'(HOUR_SEC)
               + SEC_W'(dec.minute) * SEC_W'(MIN_SEC)
               + SEC_W'(dec.second);

  assign time_valid   = dec.valid;
  assign unix_seconds = dec.valid ? total : '0;

endmodule

// ===== rtl/rtc_registers_to_unix_seconds_top.sv =====
// Pipeline: an accepted request passes through the input, decode and result registers.
// Throughput: one request per cycle while out_tready is high; a low out_tready stalls the pipeline.
// Stalls propagate back stage by stage; in_tready falls only when every stage is full.
// Reset: synchronous active-low rst_n clears all stage valid flags; payload is not reset.
module rtc_registers_to_unix_seconds_top
  import rtrus_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // raw_second, raw_minute, raw_hour, raw_day, raw_month, raw_year, status_byte
  input  logic [RAW_W-1:0] in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // unix_seconds[33:0], zero pad
  output logic [39:0]      out_tdata,
  // time_valid
  output logic [0:0]       out_tuser
);

  logic             s0_v_r;
  rtrus_raw_t       s0_raw_r;
  logic             s1_v_r;
  rtrus_dec_t       s1_dec_r;
  logic             out_v_r;
  logic             out_ok_r;
  logic [SEC_W-1:0] out_sec_r;

  rtrus_dec_t       dec;
  logic             sec_ok;
  logic [SEC_W-1:0] sec_val;
  logic             s0_adv;
  logic             s1_adv;

  assign s1_adv    = !out_v_r || out_tready;
  assign s0_adv    = !s1_v_r || s1_adv;
  assign in_tready = !s0_v_r || s0_adv;

  rtrus_decode u_decode (
    .raw (s0_raw_r),
    .dec (dec)
  );

  rtrus_seconds u_seconds (
    .dec          (s1_dec_r),
    .time_valid   (sec_ok),
    .unix_seconds (sec_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s0_v_r <= in_tvalid;
      end
      if (s0_adv) begin
        s1_v_r <= s0_v_r;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_raw_r <= rtrus_raw_t'(in_tdata);
    end
    if (s0_adv) begin
      s1_dec_r <= dec;
    end
    if (s1_adv) begin
      out_ok_r  <= sec_ok;
      out_sec_r <= sec_val;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_sec_r};
  assign out_tuser  = out_ok_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 40'd0)
    else $error("invalid result carries nonzero seconds");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_dec_r))
    else $error("decode stage overwritten while stalled");

  a_s0_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s0_v_r)
    else $error("accepted request not captured");

  a_days_floor: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_dec_r.valid |-> s1_dec_r.days >= DAYS_W'(10957))
    else $error("day count below year 2000");

endmodule
